// ----- rtl/icv_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register indexes and helpers for the interval clip-to-volume block.
// No dependencies; the design modules import this package.
package icv_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 32;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_INTERCEPT_HIT  = 3'd0,
		CFG_ENTRY_DISTANCE = 3'd1,
		CFG_EXIT_DISTANCE  = 3'd2,
		CFG_SELECT_OUTSIDE = 3'd3,
		CFG_DROP_EMPTY     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic               intercept_hit;
		logic signed [31:0] entry_distance;
		logic signed [31:0] exit_distance;
		logic               select_outside;
		logic               drop_empty;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] segment_distance;
		logic signed [31:0] step_low;
		logic signed [31:0] step_high;
	} step_t;

	// Volume boundaries moved into segment coordinates, exact in 33 bits.
	typedef struct packed {
		logic signed [32:0] din;
		logic signed [32:0] dout;
		logic signed [31:0] lo;
		logic signed [31:0] hi;
	} bound_t;

	typedef struct packed {
		logic               keep;
		logic               nodrop;
		logic               split;
		logic               modified;
		logic signed [32:0] a_lo;
		logic signed [32:0] a_hi;
		logic signed [32:0] b_lo;
		logic signed [31:0] b_hi;
	} clip_t;

	typedef struct packed {
		logic signed [31:0] clip_low;
		logic signed [31:0] clip_high;
		logic               was_modified;
		logic               last_of_item;
	} result_t;

	// Clamp a 33-bit value to the signed 32-bit range.
	function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
		logic signed [31:0] r;
		if (x[32] != x[31]) begin
			r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/icv_step_if.sv -----
`timescale 1ns / 1ps
// Input channel: one step interval per transaction, valid/ready handshake.
// No dependencies.
interface icv_step_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] segment_distance;
	logic signed [31:0] step_low;
	logic signed [31:0] step_high;

	modport source(output valid, segment_distance, step_low, step_high, input ready);
	modport sink(input valid, segment_distance, step_low, step_high, output ready);
endinterface

// ----- rtl/icv_result_if.sv -----
`timescale 1ns / 1ps
// Result channel: one clipped interval per transaction, valid/ready handshake.
// No dependencies.
interface icv_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] clip_low;
	logic signed [31:0] clip_high;
	logic               was_modified;
	logic               last_of_item;

	modport source(output valid, clip_low, clip_high, was_modified, last_of_item,
		input ready);
	modport sink(input valid, clip_low, clip_high, was_modified, last_of_item,
		output ready);
endinterface

// ----- rtl/interval_clip_to_volume.sv -----
`timescale 1ns / 1ps
// Interval clip-to-volume: clips each step interval to the part of a ray inside
// (or, in reverse mode, outside) a volume. Depends on icv_pkg, icv_step_if,
// icv_result_if, icv_bound, icv_clip and icv_emit.
//
// Users: the block is a three-stage pipeline (boundary subtract, compare and
// select, saturate and emit) that accepts one step transaction per cycle while
// the output side does not stall it; each result leaves the emit register. A
// step that splits in reverse mode produces two result transactions and holds
// the emit stage until its second half is taken, so without backpressure steady
// throughput is one step per cycle, or one result per cycle when splits occur.
// Steps that produce no result (a miss in normal mode, or an empty result with
// drop_empty set) take no extra slot: they pass through the pipeline in their
// slot and that output slot carries no result. Write configuration only while
// the pipeline is empty; all five registers reset to zero.
module interval_clip_to_volume
	import icv_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	icv_step_if.sink            step,
	icv_result_if.source        result
);

	cfg_t    cfg_q;
	step_t   step_data;
	logic    bound_valid;
	logic    bound_ready;
	bound_t  bound_data;
	logic    clip_valid;
	logic    clip_ready;
	clip_t   clip_data;
	result_t res_data;

	// Configuration write decode; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INTERCEPT_HIT:  cfg_q.intercept_hit  <= cfg_wdata[0];
				CFG_ENTRY_DISTANCE: cfg_q.entry_distance <= cfg_wdata;
				CFG_EXIT_DISTANCE:  cfg_q.exit_distance  <= cfg_wdata;
				CFG_SELECT_OUTSIDE: cfg_q.select_outside <= cfg_wdata[0];
				CFG_DROP_EMPTY:     cfg_q.drop_empty     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign step_data.segment_distance = step.segment_distance;
	assign step_data.step_low         = step.step_low;
	assign step_data.step_high        = step.step_high;

	// Stage 1: move entry/exit into segment coordinates.
	icv_bound u_bound (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (step.valid),
		.in_ready  (step.ready),
		.in_data   (step_data),
		.out_valid (bound_valid),
		.out_ready (bound_ready),
		.out_data  (bound_data)
	);

	// Stage 2: classify the step against the volume and select kept parts.
	icv_clip u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (bound_valid),
		.in_ready  (bound_ready),
		.in_data   (bound_data),
		.out_valid (clip_valid),
		.out_ready (clip_ready),
		.out_data  (clip_data)
	);

	// Stage 3: saturate, drop empties, sequence the halves of a split.
	icv_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (clip_valid),
		.in_ready  (clip_ready),
		.in_data   (clip_data),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (res_data)
	);

	assign result.clip_low     = res_data.clip_low;
	assign result.clip_high    = res_data.clip_high;
	assign result.was_modified = res_data.was_modified;
	assign result.last_of_item = res_data.last_of_item;

	// A first half is always followed directly by its second half.
	a_split_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && !result.last_of_item)
		|=> (result.valid && result.last_of_item))
		else $error("second half of split did not follow");

	// Both halves of a split carry the same modified flag.
	a_split_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && !result.last_of_item)
		|=> (result.was_modified == $past(result.was_modified)))
		else $error("split halves disagree on was_modified");

	// Input backpressure only when the output side is holding the pipeline.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!step.ready |-> (result.valid && (!result.ready || !result.last_of_item)))
		else $error("input stalled without output backpressure");

endmodule

// ----- rtl/icv_bound.sv -----
`timescale 1ns / 1ps
// Stage 1: subtract the segment distance from the entry and exit distances.
// Depends on icv_pkg.
module icv_bound
	import icv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   in_valid,
	output logic   in_ready,
	input  step_t  in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output bound_t out_data
);

	logic   vld_s1;
	bound_t data_s1;

	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.din  <= $signed({cfg.entry_distance[31], cfg.entry_distance})
				- $signed({in_data.segment_distance[31], in_data.segment_distance});
			data_s1.dout <= $signed({cfg.exit_distance[31], cfg.exit_distance})
				- $signed({in_data.segment_distance[31], in_data.segment_distance});
			data_s1.lo   <= in_data.step_low;
			data_s1.hi   <= in_data.step_high;
		end
	end

endmodule

// ----- rtl/icv_clip.sv -----
`timescale 1ns / 1ps
// Stage 2: compare the step against the boundaries and pick the kept part(s).
// Depends on icv_pkg.
module icv_clip
	import icv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   in_valid,
	output logic   in_ready,
	input  bound_t in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output clip_t  out_data
);

	logic               vld_s2;
	clip_t              data_s2;
	clip_t              nxt;
	logic signed [32:0] lo33;
	logic signed [32:0] hi33;
	logic               lo_lt_in;
	logic               hi_lt_in;
	logic               lo_lt_out;
	logic               hi_lt_out;
	logic               rev;

	assign lo33      = {in_data.lo[31], in_data.lo};
	assign hi33      = {in_data.hi[31], in_data.hi};
	assign lo_lt_in  = lo33 < in_data.din;
	assign hi_lt_in  = hi33 < in_data.din;
	assign lo_lt_out = lo33 < in_data.dout;
	assign hi_lt_out = hi33 < in_data.dout;
	assign rev       = cfg.select_outside;

	always_comb begin
		nxt.keep     = 1'b1;
		nxt.nodrop   = 1'b0;
		nxt.split    = 1'b0;
		nxt.modified = 1'b1;
		nxt.a_lo     = lo33;
		nxt.a_hi     = hi33;
		nxt.b_lo     = in_data.dout;
		nxt.b_hi     = in_data.hi;
		if (!cfg.intercept_hit) begin
			// Miss: pass untouched in reverse mode, nothing otherwise.
			nxt.keep     = rev;
			nxt.nodrop   = 1'b1;
			nxt.modified = 1'b0;
		end else if (lo_lt_in) begin
			if (hi_lt_in) begin
				if (rev) begin
					nxt.modified = 1'b0;
				end else begin
					nxt.a_lo = '0;
					nxt.a_hi = '0;
				end
			end else if (hi_lt_out) begin
				if (rev) nxt.a_hi = in_data.din;
				else nxt.a_lo = in_data.din;
			end else begin
				if (rev) begin
					nxt.split = 1'b1;
					nxt.a_hi  = in_data.din;
				end else begin
					nxt.a_lo = in_data.din;
					nxt.a_hi = in_data.dout;
				end
			end
		end else if (lo_lt_out) begin
			if (hi_lt_out) begin
				if (rev) begin
					nxt.a_lo = '0;
					nxt.a_hi = '0;
				end else begin
					nxt.modified = 1'b0;
				end
			end else begin
				if (rev) nxt.a_lo = in_data.dout;
				else nxt.a_hi = in_data.dout;
			end
		end else begin
			if (rev) begin
				nxt.modified = 1'b0;
			end else begin
				nxt.a_lo = '0;
				nxt.a_hi = '0;
			end
		end
	end

	assign in_ready  = !vld_s2 || out_ready;
	assign out_valid = vld_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_ready) begin
			vld_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= nxt;
		end
	end

endmodule

// ----- rtl/icv_emit.sv -----
`timescale 1ns / 1ps
// Stage 3: saturate, drop empty results and hand out one or two result transactions.
// Depends on icv_pkg.
module icv_emit
	import icv_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_ready,
	input  clip_t   in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic               vld_s3;
	logic               second_s3;
	logic               split_s3;
	logic               mod_s3;
	logic signed [31:0] a_lo_s3;
	logic signed [31:0] a_hi_s3;
	logic signed [31:0] b_lo_s3;
	logic signed [31:0] b_hi_s3;
	logic signed [31:0] a_lo_sat;
	logic signed [31:0] a_hi_sat;
	logic               emit;
	logic               last;

	assign a_lo_sat = sat33(in_data.a_lo);
	assign a_hi_sat = sat33(in_data.a_hi);
	// Drop a zero-length first result (and its split partner) when asked.
	assign emit = in_data.keep
		&& (in_data.nodrop || !cfg.drop_empty || (a_lo_sat != a_hi_sat));

	assign last     = !split_s3 || second_s3;
	assign in_ready = !vld_s3 || (out_ready && last);

	assign out_valid             = vld_s3;
	assign out_data.clip_low     = second_s3 ? b_lo_s3 : a_lo_s3;
	assign out_data.clip_high    = second_s3 ? b_hi_s3 : a_hi_s3;
	assign out_data.was_modified = mod_s3;
	assign out_data.last_of_item = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3    <= 1'b0;
			second_s3 <= 1'b0;
			split_s3  <= 1'b0;
		end else if (in_ready) begin
			vld_s3    <= in_valid && emit;
			second_s3 <= 1'b0;
			split_s3  <= in_data.split;
		end else if (out_ready) begin
			// First half of a split taken: advance to the second half.
			second_s3 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mod_s3  <= in_data.modified;
			a_lo_s3 <= a_lo_sat;
			a_hi_s3 <= a_hi_sat;
			b_lo_s3 <= sat33(in_data.b_lo);
			b_hi_s3 <= in_data.b_hi;
		end
	end

endmodule
